// ===== sv/olist_pkg.sv =====
// shared types and constants for the ordered list engine
package olist_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int POS_W  = 7;
    localparam int STAT_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_POS   = 3'd1,
        FN_INS_END   = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_POS   = 3'd4,
        FN_DEL_END   = 3'd5,
        FN_SEARCH    = 3'd6,
        FN_LENGTH    = 3'd7
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BAD_POS   = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GRAB,
        S_WALK,
        S_PLACE,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  value;
        logic [POS_W-1:0]          fpos;
        logic [POS_W-1:0]          count;
    } res_t;

endpackage

// ===== sv/ordered_list_engine.sv =====
// flow: an input beat is taken in S_IDLE and checked in S_CHECK, which also finishes length, failures
// and front or end insert; front or end delete reads its element in S_GRAB; mid-list insert, mid-list
// delete and search walk the store one element per cycle through its single read port in S_WALK;
// mid-list insert then writes its element in S_PLACE; all results leave from S_DONE. One item is in
// the sequencer at a time, the next input beat only back in S_IDLE; it is taken while a result waits.
// reset (aresetn low, synchronous) empties the list; the element store is not cleared.
module ordered_list_engine #(
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [olist_pkg::FUNC_W-1:0]         s_func,
    input  logic signed [olist_pkg::DATA_W-1:0]  s_element,
    input  logic [olist_pkg::POS_W-1:0]          s_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [olist_pkg::STAT_W-1:0]         m_status,
    output logic signed [olist_pkg::DATA_W-1:0]  m_value,
    output logic [olist_pkg::POS_W-1:0]          m_found_position,
    output logic [olist_pkg::POS_W-1:0]          m_count
);

    localparam int SW = $clog2(DEPTH);

    logic                                res_valid;
    logic                                res_ready;
    olist_pkg::res_t                     res;
    logic                                ram_we;
    logic [SW-1:0]                       ram_waddr;
    logic signed [olist_pkg::DATA_W-1:0] ram_wdata;
    logic                                ram_re;
    logic [SW-1:0]                       ram_raddr;
    logic signed [olist_pkg::DATA_W-1:0] ram_rdata;

    logic            m_valid_reg;
    olist_pkg::res_t out_reg;

    olist_seq #(.DEPTH(DEPTH)) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_element  (s_element),
        .s_position (s_position),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    olist_ram #(.DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register takes a new result once the old beat is gone
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_reg.status;
    assign m_value          = out_reg.value;
    assign m_found_position = out_reg.fpos;
    assign m_count          = out_reg.count;

endmodule

// ===== sv/olist_ram.sv =====
// element store: one write port, one read port, registered read data
module olist_ram #(
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [$clog2(DEPTH)-1:0]             waddr,
    input  logic signed [olist_pkg::DATA_W-1:0]  wdata,
    input  logic                                 re,
    input  logic [$clog2(DEPTH)-1:0]             raddr,
    output logic signed [olist_pkg::DATA_W-1:0]  rdata
);

    logic signed [olist_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [olist_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/olist_seq.sv =====
// operation sequencer: checks, walks the store and builds the result
module olist_seq #(
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [olist_pkg::FUNC_W-1:0]         s_func,
    input  logic signed [olist_pkg::DATA_W-1:0]  s_element,
    input  logic [olist_pkg::POS_W-1:0]          s_position,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output olist_pkg::res_t                      res,
    output logic                                 ram_we,
    output logic [$clog2(DEPTH)-1:0]             ram_waddr,
    output logic signed [olist_pkg::DATA_W-1:0]  ram_wdata,
    output logic                                 ram_re,
    output logic [$clog2(DEPTH)-1:0]             ram_raddr,
    input  logic signed [olist_pkg::DATA_W-1:0]  ram_rdata
);

    localparam int SW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int POS_W = olist_pkg::POS_W;

    olist_pkg::seq_state_t state_reg, state_next;
    olist_pkg::func_t      func_reg, func_next;
    logic signed [olist_pkg::DATA_W-1:0] elem_reg, elem_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [SW-1:0]         first_reg, first_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         wi_reg, wi_next;
    logic [CW-1:0]         wend_reg, wend_next;
    logic [CW-1:0]         ridx_reg, ridx_next;
    logic                  iss_reg, iss_next;
    logic                  pend_reg, pend_next;
    olist_pkg::status_t    rstat_reg, rstat_next;
    logic signed [olist_pkg::DATA_W-1:0] rval_reg, rval_next;
    logic [POS_W-1:0]      rpos_reg, rpos_next;

    logic          empty, full, pos_bad;
    logic [CW-1:0] posm1;
    logic [SW-1:0] first_dec, first_inc;

    // circular slot of list index idx
    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] first,
                                              input logic [CW-1:0] idx);
        logic [SW:0] sum;
        sum = {1'b0, first} + (SW+1)'(idx);
        if (sum >= (SW+1)'(DEPTH)) begin
            sum = sum - (SW+1)'(DEPTH);
        end
        return sum[SW-1:0];
    endfunction

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign pos_bad   = (pos_reg == '0) || (pos_reg > POS_W'(count_reg));
    assign posm1     = CW'(pos_reg - POS_W'(1));
    assign first_dec = (first_reg == '0) ? SW'(DEPTH - 1) : first_reg - SW'(1);
    assign first_inc = (first_reg == SW'(DEPTH - 1)) ? '0 : first_reg + SW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= olist_pkg::S_IDLE;
            first_reg <= '0;
            count_reg <= '0;
            iss_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            first_reg <= first_next;
            count_reg <= count_next;
            iss_reg   <= iss_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        elem_reg  <= elem_next;
        pos_reg   <= pos_next;
        wi_reg    <= wi_next;
        wend_reg  <= wend_next;
        ridx_reg  <= ridx_next;
        rstat_reg <= rstat_next;
        rval_reg  <= rval_next;
        rpos_reg  <= rpos_next;
    end

    always_comb begin
        state_next = state_reg;
        func_next  = func_reg;
        elem_next  = elem_reg;
        pos_next   = pos_reg;
        first_next = first_reg;
        count_next = count_reg;
        wi_next    = wi_reg;
        wend_next  = wend_reg;
        ridx_next  = ridx_reg;
        iss_next   = 1'b0;
        pend_next  = 1'b0;
        rstat_next = rstat_reg;
        rval_next  = rval_reg;
        rpos_next  = rpos_reg;
        s_ready    = 1'b0;
        res_valid  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = first_reg;
        ram_wdata  = elem_reg;
        ram_re     = 1'b0;
        ram_raddr  = first_reg;

        unique case (state_reg)
            olist_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next  = olist_pkg::func_t'(s_func);
                    elem_next  = s_element;
                    pos_next   = s_position;
                    state_next = olist_pkg::S_CHECK;
                end
            end

            olist_pkg::S_CHECK: begin
                rval_next  = '0;
                rpos_next  = '0;
                state_next = olist_pkg::S_DONE;
                unique case (func_reg) inside
                    olist_pkg::FN_INS_FRONT, olist_pkg::FN_INS_POS: begin
                        if (func_reg == olist_pkg::FN_INS_POS && empty) begin
                            rstat_next = olist_pkg::ST_EMPTY;
                        end else if (func_reg == olist_pkg::FN_INS_POS && pos_bad) begin
                            rstat_next = olist_pkg::ST_BAD_POS;
                        end else if (full) begin
                            rstat_next = olist_pkg::ST_FULL;
                        end else if (func_reg == olist_pkg::FN_INS_FRONT ||
                                     pos_reg == POS_W'(1)) begin
                            ram_we     = 1'b1;
                            ram_waddr  = first_dec;
                            first_next = first_dec;
                            count_next = count_reg + CW'(1);
                            rstat_next = olist_pkg::ST_OK;
                            rval_next  = elem_reg;
                            rpos_next  = POS_W'(1);
                        end else begin
                            // shift the tail up by one, last element first
                            wi_next    = count_reg - CW'(1);
                            wend_next  = posm1;
                            iss_next   = 1'b1;
                            rstat_next = olist_pkg::ST_OK;
                            rval_next  = elem_reg;
                            rpos_next  = pos_reg;
                            state_next = olist_pkg::S_WALK;
                        end
                    end
                    olist_pkg::FN_INS_END: begin
                        if (full) begin
                            rstat_next = olist_pkg::ST_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = slot_of(first_reg, count_reg);
                            count_next = count_reg + CW'(1);
                            rstat_next = olist_pkg::ST_OK;
                            rval_next  = elem_reg;
                            rpos_next  = POS_W'(count_reg) + POS_W'(1);
                        end
                    end
                    olist_pkg::FN_DEL_FRONT, olist_pkg::FN_DEL_POS,
                    olist_pkg::FN_DEL_END: begin
                        if (empty) begin
                            rstat_next = olist_pkg::ST_EMPTY;
                        end else if (func_reg == olist_pkg::FN_DEL_POS && pos_bad) begin
                            rstat_next = olist_pkg::ST_BAD_POS;
                        end else if (func_reg == olist_pkg::FN_DEL_FRONT ||
                                     (func_reg == olist_pkg::FN_DEL_POS &&
                                      pos_reg == POS_W'(1))) begin
                            ram_re     = 1'b1;
                            ram_raddr  = first_reg;
                            first_next = first_inc;
                            count_next = count_reg - CW'(1);
                            rstat_next = olist_pkg::ST_OK;
                            rpos_next  = POS_W'(1);
                            state_next = olist_pkg::S_GRAB;
                        end else if (func_reg == olist_pkg::FN_DEL_END ||
                                     pos_reg == POS_W'(count_reg)) begin
                            // last element: no shift needed
                            ram_re     = 1'b1;
                            ram_raddr  = slot_of(first_reg, count_reg - CW'(1));
                            count_next = count_reg - CW'(1);
                            rstat_next = olist_pkg::ST_OK;
                            rpos_next  = POS_W'(count_reg);
                            state_next = olist_pkg::S_GRAB;
                        end else begin
                            wi_next    = posm1;
                            wend_next  = count_reg - CW'(1);
                            iss_next   = 1'b1;
                            rstat_next = olist_pkg::ST_OK;
                            rpos_next  = pos_reg;
                            state_next = olist_pkg::S_WALK;
                        end
                    end
                    olist_pkg::FN_SEARCH: begin
                        if (empty) begin
                            rstat_next = olist_pkg::ST_EMPTY;
                        end else begin
                            wi_next    = '0;
                            wend_next  = count_reg - CW'(1);
                            iss_next   = 1'b1;
                            rstat_next = olist_pkg::ST_NOT_FOUND;
                            state_next = olist_pkg::S_WALK;
                        end
                    end
                    olist_pkg::FN_LENGTH: begin
                        rstat_next = empty ? olist_pkg::ST_EMPTY : olist_pkg::ST_OK;
                    end
                    default: begin
                        rstat_next = olist_pkg::ST_OK;
                    end
                endcase
            end

            olist_pkg::S_GRAB: begin
                rval_next  = ram_rdata;
                state_next = olist_pkg::S_DONE;
            end

            olist_pkg::S_WALK: begin
                // issue one read a cycle, handle the data of the previous read
                if (iss_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_of(first_reg, wi_reg);
                    ridx_next = wi_reg;
                    pend_next = 1'b1;
                    if (wi_reg != wend_reg) begin
                        iss_next = 1'b1;
                        wi_next  = (func_reg == olist_pkg::FN_INS_POS) ?
                                   wi_reg - CW'(1) : wi_reg + CW'(1);
                    end
                end
                if (pend_reg) begin
                    case (func_reg)
                        olist_pkg::FN_INS_POS: begin
                            ram_we    = 1'b1;
                            ram_waddr = slot_of(first_reg, ridx_reg + CW'(1));
                            ram_wdata = ram_rdata;
                        end
                        olist_pkg::FN_DEL_POS: begin
                            if (ridx_reg == posm1) begin
                                rval_next = ram_rdata;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = slot_of(first_reg, ridx_reg - CW'(1));
                                ram_wdata = ram_rdata;
                            end
                        end
                        default: begin
                            if (ram_rdata == elem_reg) begin
                                rstat_next = olist_pkg::ST_OK;
                                rval_next  = elem_reg;
                                rpos_next  = POS_W'(ridx_reg) + POS_W'(1);
                                iss_next   = 1'b0;
                                pend_next  = 1'b0;
                                state_next = olist_pkg::S_DONE;
                            end
                        end
                    endcase
                end
                if (!iss_reg && !pend_reg) begin
                    case (func_reg)
                        olist_pkg::FN_INS_POS: state_next = olist_pkg::S_PLACE;
                        olist_pkg::FN_DEL_POS: begin
                            count_next = count_reg - CW'(1);
                            state_next = olist_pkg::S_DONE;
                        end
                        default: state_next = olist_pkg::S_DONE;
                    endcase
                end
            end

            olist_pkg::S_PLACE: begin
                ram_we     = 1'b1;
                ram_waddr  = slot_of(first_reg, posm1);
                count_next = count_reg + CW'(1);
                state_next = olist_pkg::S_DONE;
            end

            olist_pkg::S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = olist_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = olist_pkg::S_IDLE;
            end
        endcase
    end

    assign res.status = rstat_reg;
    assign res.value  = rval_reg;
    assign res.fpos   = rpos_reg;
    assign res.count  = POS_W'(count_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("element count above store depth");

    a_first_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        first_reg <= SW'(DEPTH - 1))
        else $error("first slot outside store");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("shift reads and writes the same slot");

    a_pend_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(ram_re))
        else $error("read data consumed without a read");

endmodule
